// ----- design/pmp_pkg.sv -----
// Shared types, constants and window helper functions for the padded max pooling block.
package pmp_pkg;

  localparam int unsigned MAX_COLS_DEF = 64;
  localparam int unsigned MAX_POOL_DEF = 4;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned PIX_W        = 16;

  typedef enum logic [2:0] {
    REG_IN_ROWS   = 3'd0,
    REG_IN_COLS   = 3'd1,
    REG_OUT_SIZE  = 3'd2,
    REG_POOL_SIZE = 3'd3,
    REG_PAD       = 3'd4,
    REG_STRIDE    = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SKIP,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } back_state_e;

  // Effective settings after zero and saturation handling.
  typedef struct packed {
    logic [6:0] rows;
    logic [6:0] cols;
    logic [6:0] osz;
    logic [3:0] pool;
    logic [1:0] pad;
    logic [2:0] stride;
  } cfg_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel;
    logic [5:0]              row;
    logic [6:0]              col;
    logic                    first;
    logic                    col0;
  } item_t;

  typedef logic signed [11:0] pos_t;

  function automatic pos_t to_pos(logic [6:0] v);
    return $signed({5'd0, v});
  endfunction

  function automatic pos_t win_end(pos_t s, logic [3:0] p);
    return s + $signed({8'd0, p}) - 12'sd1;
  endfunction

  // A window starting at s ends its real part at position cur of an axis of length n.
  function automatic logic fires(pos_t s, logic [6:0] idx, logic [6:0] lim,
                                 logic [6:0] n, logic [6:0] cur, logic [3:0] p);
    logic at_end;
    at_end = (cur == n - 7'd1);
    return (idx < lim) && (at_end ? (s <= to_pos(n) - 12'sd1)
                                  : (win_end(s, p) == to_pos(cur)));
  endfunction

  function automatic logic passed(pos_t s, logic [6:0] idx, logic [6:0] lim,
                                  logic [6:0] cur, logic [3:0] p);
    return (idx < lim) && (win_end(s, p) < to_pos(cur));
  endfunction

  function automatic logic padded(pos_t s, logic [6:0] n, logic [3:0] p);
    return (s < 12'sd0) || (win_end(s, p) > to_pos(n) - 12'sd1);
  endfunction

  // This is the last output index on this axis, or no later window on it overlaps the image.
  function automatic logic last_win(pos_t s, logic [6:0] idx, logic [6:0] lim,
                                    logic [6:0] n, logic [2:0] st);
    return (idx == lim - 7'd1) || (s + $signed({9'd0, st}) > to_pos(n) - 12'sd1);
  endfunction

endpackage

// ----- design/pmp_queue.sv -----
// Short word queue between the classifying front and the pooling back end.
module pmp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pmp_pkg::item_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output pmp_pkg::item_t data_o,
  output logic          empty_o
);
  localparam int unsigned PTR_W = $clog2(pmp_pkg::QDEPTH);

  pmp_pkg::item_t    mem_q [pmp_pkg::QDEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [PTR_W:0]    cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(pmp_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(pmp_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(pmp_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// ----- design/pmp_front.sv -----
// Input front end: accepts pixels and tags each with its row and column in the plane.
module pmp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pmp_pkg::cfg_t                  cfg_i,
  input  logic                           cfg_we_i,
  input  logic signed [pmp_pkg::PIX_W-1:0] pixel_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           q_full_i,
  output logic                           push_o,
  output pmp_pkg::item_t                 item_o
);
  logic [5:0] row_q, row_d;
  logic [6:0] col_q, col_d;
  logic [5:0] r;
  logic [6:0] c;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    r = ({1'b0, row_q} >= cfg_i.rows) ? '0 : row_q;
    c = (col_q >= cfg_i.cols) ? '0 : col_q;
    item_o.pixel = pixel_i;
    item_o.row   = r;
    item_o.col   = c;
    item_o.first = (r == '0) && (c == '0);
    item_o.col0  = (c == '0);
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (push_o) begin
      if (c + 7'd1 >= cfg_i.cols) begin
        col_d = '0;
        row_d = ({1'b0, r} + 7'd1 >= cfg_i.rows) ? '0 : r + 6'd1;
      end else begin
        col_d = c + 7'd1;
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end
endmodule

// ----- design/pmp_back.sv -----
// Pooling back end: line store, window enumeration and serial window maximum.
module pmp_back #(
  parameter int unsigned MAX_COLS = pmp_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_POOL = pmp_pkg::MAX_POOL_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pmp_pkg::cfg_t                    cfg_i,
  input  logic                             q_empty_i,
  input  pmp_pkg::item_t                   q_data_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [pmp_pkg::PIX_W-1:0] pooled_value_o,
  output logic [5:0]                       out_row_o,
  output logic [5:0]                       out_col_o,
  output logic                             end_of_run_o,
  output logic                             plane_done_o
);
  localparam int unsigned DEPTH = MAX_POOL * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = $clog2(MAX_POOL);

  typedef logic signed [pmp_pkg::PIX_W-1:0] pix_t;

  pix_t mem [DEPTH];

  pmp_pkg::back_state_e state_q, state_d;
  pmp_pkg::item_t it_q, it_d;
  logic [SW-1:0]  slot_q, slot_d, ws_q, ws_d;
  logic [6:0]     j_q, j_d, k_q, k_d, jc_q, jc_d, kc_q, kc_d;
  pmp_pkg::pos_t  rs_q, rs_d, cs_q, cs_d, rsc_q, rsc_d, csc_q, csc_d, stp, dneg;
  logic [6:0]     wy_q, wy_d, wx_q, wx_d, y0_q, y0_d, x0_q, x0_d, r7;
  logic           pad_q, pad_d, rdv_q, rd_en, wr_en, load;
  pix_t           acc_q, acc_d, rdata_q, best;
  logic [AW-1:0]  raddr, waddr;
  logic           row_ok, col_ok, col_nx, row_nx;
  logic           ov_q;
  pix_t           ov_val_q;
  logic [5:0]     ov_row_q, ov_col_q;
  logic           ov_eor_q, ov_pd_q;

  assign r7    = {1'b0, it_q.row};
  assign stp   = $signed({9'd0, cfg_i.stride});
  assign dneg  = -$signed({10'd0, cfg_i.pad});
  assign raddr = AW'(ws_q) * AW'(MAX_COLS) + AW'(wx_q);
  assign waddr = AW'(slot_q) * AW'(MAX_COLS) + AW'(it_q.col);

  always_comb begin
    row_ok = pmp_pkg::fires(rsc_q, jc_q, cfg_i.osz, cfg_i.rows, r7, cfg_i.pool);
    col_ok = pmp_pkg::fires(csc_q, kc_q, cfg_i.osz, cfg_i.cols, it_q.col, cfg_i.pool);
    col_nx = pmp_pkg::fires(csc_q + stp, kc_q + 7'd1, cfg_i.osz, cfg_i.cols,
                            it_q.col, cfg_i.pool);
    row_nx = pmp_pkg::fires(rsc_q + stp, jc_q + 7'd1, cfg_i.osz, cfg_i.rows,
                            r7, cfg_i.pool);
    best   = (rdata_q > acc_q) ? rdata_q : acc_q;
    if (pad_q && best < 0) begin
      best = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    slot_d  = slot_q;
    j_d = j_q;   rs_d = rs_q;   k_d = k_q;   cs_d = cs_q;
    jc_d = jc_q; rsc_d = rsc_q; kc_d = kc_q; csc_d = csc_q;
    wy_d = wy_q; wx_d = wx_q;   ws_d = ws_q;
    y0_d = y0_q; x0_d = x0_q;   pad_d = pad_q;
    acc_d = (rdv_q && rdata_q > acc_q) ? rdata_q : acc_q;
    pop_o = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    load  = 1'b0;
    case (state_q)
      pmp_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          it_d  = q_data_i;
          if (q_data_i.first) begin
            slot_d = '0;
          end else if (q_data_i.col0) begin
            slot_d = (slot_q == SW'(MAX_POOL - 1)) ? '0 : slot_q + 1'b1;
          end
          state_d = pmp_pkg::ST_WRITE;
        end
      end
      pmp_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (it_q.first) begin
          j_d  = '0;
          rs_d = dneg;
        end
        if (it_q.col0) begin
          k_d  = '0;
          cs_d = dneg;
        end
        state_d = pmp_pkg::ST_SKIP;
      end
      pmp_pkg::ST_SKIP: begin
        // Windows that ended before this position never fire again.
        if (pmp_pkg::passed(rs_q, j_q, cfg_i.osz, r7, cfg_i.pool)) begin
          j_d  = j_q + 7'd1;
          rs_d = rs_q + stp;
        end else if (pmp_pkg::passed(cs_q, k_q, cfg_i.osz, it_q.col, cfg_i.pool)) begin
          k_d  = k_q + 7'd1;
          cs_d = cs_q + stp;
        end else begin
          jc_d = j_q; rsc_d = rs_q; kc_d = k_q; csc_d = cs_q;
          state_d = pmp_pkg::ST_CHECK;
        end
      end
      pmp_pkg::ST_CHECK: begin
        if (row_ok && col_ok) begin
          wy_d  = r7;
          wx_d  = it_q.col;
          ws_d  = slot_q;
          y0_d  = (rsc_q < 0) ? '0 : rsc_q[6:0];
          x0_d  = (csc_q < 0) ? '0 : csc_q[6:0];
          pad_d = pmp_pkg::padded(rsc_q, cfg_i.rows, cfg_i.pool) ||
                  pmp_pkg::padded(csc_q, cfg_i.cols, cfg_i.pool);
          acc_d = pix_t'(-32768);
          state_d = pmp_pkg::ST_READ;
        end else begin
          state_d = pmp_pkg::ST_IDLE;
        end
      end
      pmp_pkg::ST_READ: begin
        rd_en = 1'b1;
        if (wx_q == x0_q) begin
          wx_d = it_q.col;
          wy_d = wy_q - 7'd1;
          ws_d = (ws_q == '0) ? SW'(MAX_POOL - 1) : ws_q - 1'b1;
          if (wy_q == y0_q) begin
            state_d = pmp_pkg::ST_DRAIN;
          end
        end else begin
          wx_d = wx_q - 7'd1;
        end
      end
      pmp_pkg::ST_DRAIN: begin
        acc_d   = best;
        state_d = pmp_pkg::ST_EMIT;
      end
      pmp_pkg::ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          load = 1'b1;
          if (col_nx) begin
            kc_d  = kc_q + 7'd1;
            csc_d = csc_q + stp;
            state_d = pmp_pkg::ST_CHECK;
          end else if (row_nx) begin
            jc_d  = jc_q + 7'd1;
            rsc_d = rsc_q + stp;
            kc_d  = k_q;
            csc_d = cs_q;
            state_d = pmp_pkg::ST_CHECK;
          end else begin
            state_d = pmp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = pmp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= it_q.pixel;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;
    j_q <= j_d;   rs_q <= rs_d;   k_q <= k_d;   cs_q <= cs_d;
    jc_q <= jc_d; rsc_q <= rsc_d; kc_q <= kc_d; csc_q <= csc_d;
    wy_q <= wy_d; wx_q <= wx_d;   ws_q <= ws_d;
    y0_q <= y0_d; x0_q <= x0_d;   pad_q <= pad_d;
    acc_q <= acc_d;
    if (load) begin
      ov_val_q <= acc_q;
      ov_row_q <= jc_q[5:0];
      ov_col_q <= kc_q[5:0];
      ov_eor_q <= !col_nx && !row_nx;
      ov_pd_q  <= pmp_pkg::last_win(rsc_q, jc_q, cfg_i.osz, cfg_i.rows, cfg_i.stride) &&
                  pmp_pkg::last_win(csc_q, kc_q, cfg_i.osz, cfg_i.cols, cfg_i.stride);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmp_pkg::ST_IDLE;
      slot_q  <= '0;
      rdv_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      rdv_q   <= rd_en;
      if (load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign pooled_value_o = ov_val_q;
  assign out_row_o      = ov_row_q;
  assign out_col_o      = ov_col_q;
  assign end_of_run_o   = ov_eor_q;
  assign plane_done_o   = ov_pd_q;
endmodule

// ----- design/padded_max_pooling.sv -----
// Top level of the padded max pooling block: settings registers and front/queue/back wiring.
// A pixel that closes no window passes the back end states IDLE, WRITE, SKIP and CHECK, with
// SKIP repeated for each window index that it steps past; an emitted window then reads its h*w
// real pixels, h and w its real rows and columns, since the line store has one read port and
// the maximum is taken one pixel per cycle, before DRAIN and EMIT. Reset restores the default
// settings and clears the plane position and all valid flags; the line store is not reset.
module padded_max_pooling #(
  parameter int unsigned MAX_COLS = pmp_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_POOL = pmp_pkg::MAX_POOL_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [2:0]                       cfg_idx_i,
  input  logic [6:0]                       cfg_data_i,
  input  logic signed [pmp_pkg::PIX_W-1:0] pixel_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic signed [pmp_pkg::PIX_W-1:0] pooled_value_o,
  output logic [5:0]                       out_row_o,
  output logic [5:0]                       out_col_o,
  output logic                             end_of_run_o,
  output logic                             plane_done_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i
);
  localparam logic [6:0] COL_LIM = (MAX_COLS > 127) ? 7'd127 : 7'(MAX_COLS);
  localparam logic [3:0] POOL_LIM = 4'(MAX_POOL);

  logic [6:0] in_rows_q, in_cols_q, out_size_q;
  logic [2:0] pool_size_q, stride_q;
  logic [1:0] pad_q;
  pmp_pkg::cfg_t  cfg;
  pmp_pkg::item_t push_item, pop_item;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rows_q   <= 7'd8;
      in_cols_q   <= 7'd8;
      out_size_q  <= 7'd4;
      pool_size_q <= 3'd2;
      pad_q       <= 2'd0;
      stride_q    <= 3'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmp_pkg::REG_IN_ROWS:   in_rows_q   <= cfg_data_i;
        pmp_pkg::REG_IN_COLS:   in_cols_q   <= cfg_data_i;
        pmp_pkg::REG_OUT_SIZE:  out_size_q  <= cfg_data_i;
        pmp_pkg::REG_POOL_SIZE: pool_size_q <= cfg_data_i[2:0];
        pmp_pkg::REG_PAD:       pad_q       <= cfg_data_i[1:0];
        pmp_pkg::REG_STRIDE:    stride_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rows   = (in_rows_q == '0) ? 7'd1 : (in_rows_q > 7'd64 ? 7'd64 : in_rows_q);
    cfg.cols   = (in_cols_q == '0) ? 7'd1 : (in_cols_q > COL_LIM ? COL_LIM : in_cols_q);
    cfg.osz    = (out_size_q == '0) ? 7'd1 : (out_size_q > 7'd64 ? 7'd64 : out_size_q);
    cfg.pool   = (pool_size_q == '0) ? 4'd1 :
                 ({1'b0, pool_size_q} > POOL_LIM ? POOL_LIM : {1'b0, pool_size_q});
    cfg.pad    = pad_q;
    cfg.stride = (stride_q == '0) ? 3'd1 : stride_q;
  end

  pmp_front u_front (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .cfg_we_i,
    .pixel_i,
    .in_valid_i,
    .in_ready_o,
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  pmp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_item),
    .empty_o (q_empty)
  );

  pmp_back #(.MAX_COLS(MAX_COLS), .MAX_POOL(MAX_POOL)) u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .pooled_value_o,
    .out_row_o,
    .out_col_o,
    .end_of_run_o,
    .plane_done_o
  );

  // The final window of a plane is always the last word for its pixel.
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && plane_done_o |-> end_of_run_o)
    else $error("plane_done without end_of_run");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_row_o} < cfg.osz)
    else $error("output row beyond output size");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_col_o} < cfg.osz)
    else $error("output column beyond output size");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");
endmodule
